FILE: hdl/rsb_pkg.sv
`timescale 1ns / 1ps

package rsb_pkg;

    // Default number of refresh slots.
    localparam int SLOTS_DEF = 8;

    // Configuration port geometry: four 32-bit registers at byte offsets 0, 4, 8 and 12.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Timing constants.
    localparam logic [23:0] BASE_RETRY_S  = 24'd60;
    localparam logic [23:0] POLL_RESET_S  = 24'd600;
    localparam logic [33:0] MS_PER_S      = 34'd1000;
    localparam logic [31:0] MIN_WAIT_MS   = 32'd100;
    localparam logic [31:0] EMPTY_WAIT_MS = 32'd60000;
    localparam logic [31:0] HALF_RANGE    = 32'h8000_0000;
    localparam logic [1:0]  MAX_STREAK    = 2'd3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_POLL    = 2'd0,
        REG_ACTIVE  = 2'd1,
        REG_COUNT   = 2'd2,
        REG_ENABLED = 2'd3
    } reg_idx_t;

    // Command codes carried by an input item.
    typedef enum logic [1:0] {
        CMD_PICK = 2'd0,
        CMD_OK   = 2'd1,
        CMD_FAIL = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    // One result item.
    typedef struct packed {
        logic        have_target;
        logic [2:0]  target_slot;
        logic        target_is_active;
        logic [31:0] wait_ms;
        logic        idle_until_change;
        logic [31:0] next_attempt_ms;
    } res_t;

endpackage

FILE: hdl/refresh_scheduler_with_backoff_unit.sv
`timescale 1ns / 1ps

// Refresh scheduler with failure back-off.
// A pick scans the used slots one by one through the shared subtract and compare unit and
// then reports; a store passes through the multiply and add states; a disabled pick, an
// unknown command or a store to an unused slot goes straight to the result.
// One item at a time: the next item is accepted once the result has moved to the output
// register. Synchronous active-low reset resets the slot records, the configuration and the control registers.
module refresh_scheduler_with_backoff_unit #(
    parameter int SLOTS = rsb_pkg::SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsb_pkg::PADDR_W-1:0] paddr,
    input  logic [rsb_pkg::PDATA_W-1:0] pwdata,
    output logic [rsb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_command,
    input  logic [2:0]                  s_slot,
    input  logic [31:0]                 s_now_ms,
    input  logic [23:0]                 s_ttl_s,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_have_target,
    output logic [2:0]                  m_target_slot,
    output logic                        m_target_is_active,
    output logic [31:0]                 m_wait_ms,
    output logic                        m_idle_until_change,
    output logic [31:0]                 m_next_attempt_ms
);
    import rsb_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Configuration registers.
    logic [23:0] poll_reg;
    logic [2:0]  active_reg;
    logic [3:0]  count_reg;
    logic        enabled_reg;

    // Slot records.
    logic        valid_reg    [SLOTS];
    logic [31:0] deadline_reg [SLOTS];
    logic [1:0]  streak_reg   [SLOTS];

    // Sequencer and working registers.
    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [2:0]        slot_reg, slot_next;
    logic [31:0]       now_reg, now_next;
    logic [23:0]       ttl_reg, ttl_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    logic              found_reg, found_next;
    logic              act_hit_reg, act_hit_next;
    logic [31:0]       min_reg, min_next;
    logic [31:0]       prod_reg, prod_next;
    res_t              res_reg, res_next;
    res_t              out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    // Record write port.
    logic              wr_en;
    logic [IDX_W-1:0]  rd_idx;

    // Shared unit signals.
    logic [CNT_W-1:0]  used_n;
    logic [31:0]       alu_a, alu_b, alu_sum;
    logic              alu_cin;
    logic [23:0]       ok_secs, big_secs, mul_a;
    logic [33:0]       mul_full;
    logic              rd_valid;
    logic [31:0]       rd_deadline;
    logic [1:0]        rd_streak;
    logic              due, eligible;
    logic [31:0]       rem;
    logic              cfg_wr;

    // Effective slot count saturates at the number of slots.
    assign used_n = (32'(count_reg) > 32'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(count_reg);

    // One record is read per cycle: the scanned slot or the slot being stored.
    always_comb begin
        if (state_reg == ST_SCAN) begin
            rd_idx = (cnt_reg < used_n) ? cnt_reg[IDX_W-1:0] : '0;
        end else begin
            rd_idx = IDX_W'(slot_reg);
        end
    end

    assign rd_valid    = valid_reg[rd_idx];
    assign rd_deadline = deadline_reg[rd_idx];
    assign rd_streak   = streak_reg[rd_idx];

    // Shared adder: deadline minus now while scanning, product plus now when storing.
    always_comb begin
        if (state_reg == ST_ADD) begin
            alu_a   = prod_reg;
            alu_b   = now_reg;
            alu_cin = 1'b0;
        end else begin
            alu_a   = rd_deadline;
            alu_b   = ~now_reg;
            alu_cin = 1'b1;
        end
    end

    assign alu_sum = alu_a + alu_b + 32'(alu_cin);

    // The slot is due when now minus deadline is not negative, or the deadline is zero.
    assign due      = (rd_deadline == 32'd0) || (alu_sum == 32'd0) || (alu_sum > HALF_RANGE);
    assign rem      = due ? 32'd0 : alu_sum;
    assign eligible = !rd_valid || due;

    // Shared multiplier: retry period in seconds times one thousand.
    assign big_secs = (ttl_reg > poll_reg) ? ttl_reg : poll_reg;
    assign ok_secs  = (big_secs < BASE_RETRY_S) ? BASE_RETRY_S : big_secs;
    assign mul_a    = (cmd_reg == CMD_OK) ? ok_secs : (BASE_RETRY_S << rd_streak);
    assign mul_full = 34'(mul_a) * MS_PER_S;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_POLL:    prdata = 32'(poll_reg);
            REG_ACTIVE:  prdata = 32'(active_reg);
            REG_COUNT:   prdata = 32'(count_reg);
            REG_ENABLED: prdata = 32'(enabled_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_reg    <= POLL_RESET_S;
            active_reg  <= '0;
            count_reg   <= '0;
            enabled_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_POLL:    poll_reg    <= pwdata[23:0];
                REG_ACTIVE:  active_reg  <= pwdata[2:0];
                REG_COUNT:   count_reg   <= pwdata[3:0];
                REG_ENABLED: enabled_reg <= pwdata[0];
                default:     poll_reg    <= poll_reg;
            endcase
        end
    end

    // Sequencer: next state and working values.
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        slot_next    = slot_reg;
        now_next     = now_reg;
        ttl_next     = ttl_reg;
        cnt_next     = cnt_reg;
        first_next   = first_reg;
        found_next   = found_reg;
        act_hit_next = act_hit_reg;
        min_next     = min_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        wr_en        = 1'b0;
        s_ready      = (state_reg == ST_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next     = cmd_t'(s_command);
                    slot_next    = s_slot;
                    now_next     = s_now_ms;
                    ttl_next     = s_ttl_s;
                    res_next     = '0;
                    cnt_next     = '0;
                    found_next   = 1'b0;
                    act_hit_next = 1'b0;
                    first_next   = '0;
                    min_next     = 32'hFFFF_FFFF;
                    state_next   = ST_DONE;
                    case (cmd_t'(s_command))
                        CMD_PICK: begin
                            if (enabled_reg) begin
                                state_next = ST_SCAN;
                            end else begin
                                res_next.idle_until_change = 1'b1;
                            end
                        end
                        CMD_OK, CMD_FAIL: begin
                            if (32'(s_slot) < 32'(used_n)) begin
                                state_next = ST_MUL;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (cnt_reg < used_n) begin
                    // Track the active slot, the first other eligible slot and the minimum.
                    if (32'(cnt_reg) == 32'(active_reg)) begin
                        act_hit_next = eligible;
                    end else if (eligible && !found_reg) begin
                        found_next = 1'b1;
                        first_next = cnt_reg[IDX_W-1:0];
                    end
                    if (rem < min_reg) begin
                        min_next = rem;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    if (act_hit_reg) begin
                        res_next.have_target      = 1'b1;
                        res_next.target_slot      = active_reg;
                        res_next.target_is_active = 1'b1;
                    end else if (found_reg) begin
                        res_next.have_target = 1'b1;
                        res_next.target_slot = 3'(first_reg);
                    end else if (used_n == '0) begin
                        res_next.wait_ms = EMPTY_WAIT_MS;
                    end else begin
                        res_next.wait_ms = (min_reg < MIN_WAIT_MS) ? MIN_WAIT_MS : min_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_MUL: begin
                prod_next  = mul_full[31:0];
                state_next = ST_ADD;
            end
            ST_ADD: begin
                wr_en                    = 1'b1;
                res_next.next_attempt_ms = alu_sum;
                state_next               = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            act_hit_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            act_hit_reg <= act_hit_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        slot_reg  <= slot_next;
        now_reg   <= now_next;
        ttl_reg   <= ttl_next;
        first_reg <= first_next;
        min_reg   <= min_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // Slot records: every store writes the new deadline; a success marks the slot valid and clears
    // the streak; a failure raises the streak, saturating at its top value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                valid_reg[i]    <= 1'b0;
                deadline_reg[i] <= '0;
                streak_reg[i]   <= '0;
            end
        end else if (wr_en) begin
            deadline_reg[rd_idx] <= alu_sum;
            if (cmd_reg == CMD_OK) begin
                valid_reg[rd_idx]  <= 1'b1;
                streak_reg[rd_idx] <= '0;
            end else begin
                streak_reg[rd_idx] <= (rd_streak == MAX_STREAK) ? MAX_STREAK
                                                                : rd_streak + 2'd1;
            end
        end
    end

    // Output ports.
    assign m_valid             = m_valid_reg;
    assign m_have_target       = out_reg.have_target;
    assign m_target_slot       = out_reg.target_slot;
    assign m_target_is_active  = out_reg.target_is_active;
    assign m_wait_ms           = out_reg.wait_ms;
    assign m_idle_until_change = out_reg.idle_until_change;
    assign m_next_attempt_ms   = out_reg.next_attempt_ms;

    // A found target never comes with a wait time or a store deadline.
    a_target_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_have_target |-> m_wait_ms == 32'd0 && m_next_attempt_ms == 32'd0)
        else $error("target result carries wait or deadline");

    // An active-slot target names the configured active slot.
    a_active_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_have_target && m_target_is_active |-> m_target_slot == active_reg)
        else $error("active target does not match active slot");

    // One item at a time: no acceptance directly after an acceptance.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while busy");

    // The scan never runs past the used slots.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> cnt_reg <= used_n)
        else $error("scan counter beyond used slots");

endmodule

FILE: bench/rsb_sched_check_pkg.sv
`timescale 1ns / 1ps

package rsb_sched_check_pkg;
    import rsb_pkg::*;

    localparam int NUM_SLOTS = SLOTS_DEF;

    // Scoreboard for the refresh scheduler: it keeps its own copy of the slot records and the
    // registers, predicts the result of every accepted item and checks the results in order.
    class refresh_checker;
        logic        rec_valid [NUM_SLOTS];
        logic [31:0] due_ms    [NUM_SLOTS];
        logic [1:0]  streak    [NUM_SLOTS];
        logic [23:0] poll_s;
        logic [2:0]  prio_slot;
        logic [3:0]  count_cfg;
        logic        sched_on;
        res_t        pending_outcomes [$];
        int          errors;

        function new();
            int i;
            for (i = 0; i < NUM_SLOTS; i++) begin
                rec_valid[i] = 1'b0;
                due_ms[i]    = '0;
                streak[i]    = '0;
            end
            poll_s    = POLL_RESET_S;
            prio_slot = '0;
            count_cfg = '0;
            sched_on  = 1'b0;
            errors    = 0;
        endfunction

        // A zero deadline is always due; otherwise the wrapped difference decides.
        function logic is_due(logic [31:0] now, logic [31:0] deadline);
            logic [31:0] diff;
            diff = now - deadline;
            return (deadline == '0) || !diff[31];
        endfunction

        function int used_slots();
            return (int'(count_cfg) > NUM_SLOTS) ? NUM_SLOTS : int'(count_cfg);
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_POLL:    poll_s    = value[23:0];
                REG_ACTIVE:  prio_slot = value[2:0];
                REG_COUNT:   count_cfg = value[3:0];
                REG_ENABLED: sched_on  = value[0];
                default: ;
            endcase
        endfunction

        // Works out the result of one item and updates the slot records.
        function res_t predict_outcome(cmd_t cmd, logic [2:0] slot, logic [31:0] now,
                                       logic [23:0] ttl);
            res_t        r;
            int          n;
            int          i;
            logic        found;
            logic [31:0] shortest;
            logic [31:0] rem;
            logic [23:0] secs;
            logic [1:0]  shift;
            logic [63:0] span;
            r = '0;
            n = used_slots();
            if (cmd == CMD_PICK) begin
                if (!sched_on) begin
                    r.idle_until_change = 1'b1;
                    return r;
                end
                found = 1'b0;
                // The active slot has first claim when it is in use.
                if (int'(prio_slot) < n &&
                    (!rec_valid[prio_slot] || is_due(now, due_ms[prio_slot]))) begin
                    found              = 1'b1;
                    r.target_slot      = prio_slot;
                    r.target_is_active = 1'b1;
                end
                for (i = 0; i < n && !found; i++) begin
                    if (i != int'(prio_slot) && (!rec_valid[i] || is_due(now, due_ms[i]))) begin
                        found         = 1'b1;
                        r.target_slot = 3'(i);
                    end
                end
                if (found) begin
                    r.have_target = 1'b1;
                end else if (n == 0) begin
                    r.wait_ms = EMPTY_WAIT_MS;
                end else begin
                    shortest = '1;
                    for (i = 0; i < n; i++) begin
                        rem = is_due(now, due_ms[i]) ? 32'd0 : due_ms[i] - now;
                        if (rem < shortest) shortest = rem;
                    end
                    r.wait_ms = (shortest < MIN_WAIT_MS) ? MIN_WAIT_MS : shortest;
                end
                return r;
            end
            if (cmd == CMD_NOP || int'(slot) >= n) return r;
            if (cmd == CMD_OK) begin
                secs = (ttl > poll_s) ? ttl : poll_s;
                if (secs < BASE_RETRY_S) secs = BASE_RETRY_S;
                rec_valid[slot] = 1'b1;
                streak[slot]    = '0;
            end else begin
                // Back-off doubles per failure; the streak saturates.
                shift        = streak[slot];
                secs         = BASE_RETRY_S << shift;
                streak[slot] = (shift == MAX_STREAK) ? MAX_STREAK : shift + 2'd1;
            end
            span             = 64'(secs) * 64'(MS_PER_S);
            due_ms[slot]     = now + span[31:0];
            r.next_attempt_ms = due_ms[slot];
            return r;
        endfunction

        function void note_request(cmd_t cmd, logic [2:0] slot, logic [31:0] now,
                                   logic [23:0] ttl);
            pending_outcomes.push_back(predict_outcome(cmd, slot, now, ttl));
        endfunction

        function void log_error(string what, res_t want, res_t got);
            errors++;
            if (errors <= 10) begin
                $display("ERROR %0t: %s", $time, what);
                $display("  expected have=%0d slot=%0d act=%0d wait=%0d idle=%0d next=%08h",
                         want.have_target, want.target_slot, want.target_is_active,
                         want.wait_ms, want.idle_until_change, want.next_attempt_ms);
                $display("  actual   have=%0d slot=%0d act=%0d wait=%0d idle=%0d next=%08h",
                         got.have_target, got.target_slot, got.target_is_active,
                         got.wait_ms, got.idle_until_change, got.next_attempt_ms);
            end
        endfunction

        function void check_outcome(res_t got);
            res_t want;
            if (pending_outcomes.size() == 0) begin
                log_error("result item with none expected", '0, got);
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.have_target !== want.have_target ||
                got.target_slot !== want.target_slot ||
                got.target_is_active !== want.target_is_active ||
                got.wait_ms !== want.wait_ms ||
                got.idle_until_change !== want.idle_until_change ||
                got.next_attempt_ms !== want.next_attempt_ms) begin
                log_error("result item mismatch", want, got);
            end
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rsb_pkg::*;
    import rsb_sched_check_pkg::*;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    wire  [PDATA_W-1:0] prdata;
    wire                pready;
    logic               s_valid   = 1'b0;
    wire                s_ready;
    logic [1:0]         s_command = CMD_PICK;
    logic [2:0]         s_slot    = '0;
    logic [31:0]        s_now_ms  = '0;
    logic [23:0]        s_ttl_s   = '0;
    wire                m_valid;
    logic               m_ready   = 1'b0;
    wire                m_have_target;
    wire  [2:0]         m_target_slot;
    wire                m_target_is_active;
    wire  [31:0]        m_wait_ms;
    wire                m_idle_until_change;
    wire  [31:0]        m_next_attempt_ms;

    refresh_checker sched_sb;
    logic           calm     = 1'b0;
    logic [31:0]    clock_ms = '0;
    int             cfg_used = 0;

    refresh_scheduler_with_backoff_unit u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_slot              (s_slot),
        .s_now_ms            (s_now_ms),
        .s_ttl_s             (s_ttl_s),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_have_target       (m_have_target),
        .m_target_slot       (m_target_slot),
        .m_target_is_active  (m_target_is_active),
        .m_wait_ms           (m_wait_ms),
        .m_idle_until_change (m_idle_until_change),
        .m_next_attempt_ms   (m_next_attempt_ms)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard limit on run time.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // The result side stalls now and then, except in the calm stretch.
    always @(negedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 11);
        end
    end

    // Check results first, then note the item accepted at the same edge.
    always @(posedge aclk) begin : monitor
        res_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_have_target, m_target_slot, m_target_is_active, m_wait_ms,
                       m_idle_until_change, m_next_attempt_ms};
                sched_sb.check_outcome(got);
            end
            if (s_valid && s_ready) begin
                sched_sb.note_request(cmd_t'(s_command), s_slot, s_now_ms, s_ttl_s);
            end
        end
    end

    // Present one item and hold it until it is accepted.
    task automatic push_request(input cmd_t cmd, input logic [2:0] slot,
                                input logic [31:0] now, input logic [23:0] ttl);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_slot    <= slot;
        s_now_ms  <= now;
        s_ttl_s   <= ttl;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sched_sb.pending() != 0) @(posedge aclk);
        repeat (14) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sched_sb.set_register(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [23:0] poll, input logic [2:0] active,
                                  input logic [3:0] count, input logic on);
        write_reg(REG_POLL, 32'(poll));
        write_reg(REG_ACTIVE, 32'(active));
        write_reg(REG_COUNT, 32'(count));
        write_reg(REG_ENABLED, 32'(on));
        cfg_used = (count > 4'd8) ? 8 : int'(count);
    endtask

    // One random item; time mostly moves forward so deadlines come due naturally.
    task automatic random_request();
        int          r;
        cmd_t        cmd;
        logic [2:0]  slot;
        logic [23:0] ttl;
        r = $urandom_range(99);
        if (r < 40) cmd = CMD_PICK;
        else if (r < 70) cmd = CMD_OK;
        else if (r < 92) cmd = CMD_FAIL;
        else cmd = CMD_NOP;

        if (cfg_used > 0 && $urandom_range(99) < 85) slot = 3'($urandom_range(cfg_used - 1));
        else slot = 3'($urandom_range(7));

        // Near a stored deadline now and then, to hit the due boundary and the wait floor.
        r = $urandom_range(99);
        if (r < 30) clock_ms = clock_ms + $urandom_range(2000);
        else if (r < 70) clock_ms = clock_ms + $urandom_range(700000);
        else if (r < 85) clock_ms = clock_ms + $urandom_range(4000000);
        else if (r < 92) clock_ms = $urandom;
        else clock_ms = sched_sb.due_ms[$urandom_range(NUM_SLOTS - 1)]
                        - $urandom_range(150) + 32'd1;

        r = $urandom_range(99);
        if (r < 35) ttl = 24'($urandom_range(100));
        else if (r < 65) ttl = 24'($urandom_range(4000));
        else if (r < 90) ttl = 24'($urandom);
        else ttl = 24'hFF_FFFF;

        push_request(cmd, slot, clock_ms, ttl);
    endtask

    initial begin : main
        int s;
        int phase;
        int k;
        sched_sb = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // After reset the scheduler is off and no slot is in use.
        push_request(CMD_PICK, 3'd0, 32'd0, 24'd0);
        push_request(CMD_OK, 3'd0, 32'd1000, 24'd0);
        drain_results();
        apply_settings(POLL_RESET_S, 3'd2, 4'd8, 1'b1);

        // Active slot invalid, then the lowest-numbered invalid slot other than it.
        push_request(CMD_PICK, 3'd0, 32'd1000, 24'd0);
        push_request(CMD_OK, 3'd2, 32'd1000, 24'd0);
        push_request(CMD_PICK, 3'd0, 32'd1000, 24'd0);
        for (s = 0; s < 8; s++) begin
            push_request(CMD_OK, 3'(s), 32'd5000, (s == 1) ? 24'd30 : 24'd700);
        end
        // Nothing due: plain wait, the wait floor, then a deadline reached exactly.
        push_request(CMD_PICK, 3'd0, 32'd5000, 24'd0);
        push_request(CMD_PICK, 3'd0, 32'd604950, 24'd0);
        push_request(CMD_PICK, 3'd0, 32'd605000, 24'd0);
        push_request(CMD_OK, 3'd7, 32'd605000, 24'hFF_FFFF);
        // Repeated failures saturate the back-off.
        repeat (4) push_request(CMD_FAIL, 3'd5, 32'd705000, 24'd0);
        push_request(CMD_NOP, 3'd3, 32'hFFFF_FFFF, 24'hFF_FFFF);
        // A deadline that wraps to zero counts as due.
        push_request(CMD_OK, 3'd6, 32'hFFF6_D840, 24'd0);
        push_request(CMD_PICK, 3'd0, 32'h1234_5678, 24'd0);

        clock_ms = 32'd800000;
        for (phase = 0; phase < 12; phase++) begin
            drain_results();
            case (phase)
                0: apply_settings(POLL_RESET_S, 3'd0, 4'd8, 1'b1);
                1: apply_settings(24'd0, 3'd7, 4'd8, 1'b1);
                2: apply_settings(24'hFF_FFFF, 3'd3, 4'd4, 1'b1);
                3: apply_settings(24'd59, 3'd5, 4'd2, 1'b1);
                4: apply_settings(BASE_RETRY_S, 3'd0, 4'd1, 1'b1);
                5: apply_settings(24'($urandom), 3'($urandom), 4'd0, 1'b1);
                6: apply_settings(24'($urandom_range(900)), 3'($urandom), 4'd15, 1'b1);
                7: apply_settings(24'($urandom_range(900)), 3'($urandom),
                                  4'($urandom_range(8)), 1'b0);
                default: apply_settings(24'($urandom_range(1200)), 3'($urandom),
                                        4'($urandom_range(8, 1)), 1'b1);
            endcase
            calm = (phase == 0);
            for (k = 0; k < 106; k++) begin
                if ($urandom_range(99) == 0) drain_results();
                random_request();
            end
        end

        drain_results();
        if (sched_sb.errors == 0 && sched_sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
